FILE: design/pix2x2_pkg.sv
// Shared constants and types for the 2x2 block-average pixelator.
`timescale 1ns / 1ps
`default_nettype none
package pix2x2_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int DIM_W      = 11;
   localparam int PIXEL_W    = 8;
   localparam int BLK_W      = 9;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int PAIR_W     = PIXEL_W + 1;
   localparam int SUM_W      = PIXEL_W + 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIM_W-1:0] MIN_DIM       = DIM_W'(2);
   localparam logic [DIM_W-1:0] MAX_WIDTH_V   = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_HEIGHT_V  = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] WIDTH_RESET   = DIM_W'(1024);
   localparam logic [DIM_W-1:0] HEIGHT_RESET  = DIM_W'(1024);

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (v < MIN_DIM) begin
         r = MIN_DIM;
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/pixelate_2x2_block_average.sv
// Top level of the 2x2 block-average pixelator with its pair-sum line memory.
`timescale 1ns / 1ps
`default_nettype none
// The block-closing request passes through stage 1 and the output register to rsp_valid.
// Throughput: one request per cycle while req_ready is high; the line memory takes at most
// one write or one read per request. req_ready drops only when the output register is full
// and not being taken. Reset (synchronous, active high) clears counters, held pixel, valids
// and sets both dimension registers to 1024. The line memory is not cleared: every entry
// is written on an even row before the odd row below reads it.
module pixelate_2x2_block_average (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [pix2x2_pkg::PIXEL_W-1:0]      req_pixel,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [pix2x2_pkg::PIXEL_W-1:0]           rsp_block_mean,
   output logic [pix2x2_pkg::BLK_W-1:0]             rsp_block_row,
   output logic [pix2x2_pkg::BLK_W-1:0]             rsp_block_col,
   output logic                                     rsp_last_block,
   // configuration port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [pix2x2_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [pix2x2_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pix2x2_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                     pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [pix2x2_pkg::DIM_W-1:0] image_width_ff;
   logic [pix2x2_pkg::DIM_W-1:0] image_height_ff;
   pix2x2_pkg::reg_index_type    csr_index;
   logic                         csr_write;

   assign pready    = 1'b1;
   assign csr_index = pix2x2_pkg::reg_index_type'(paddr[2]);
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= pix2x2_pkg::WIDTH_RESET;
         image_height_ff <= pix2x2_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            pix2x2_pkg::REG_IMAGE_WIDTH: begin
               image_width_ff <= pwdata[pix2x2_pkg::DIM_W-1:0];
            end
            pix2x2_pkg::REG_IMAGE_HEIGHT: begin
               image_height_ff <= pwdata[pix2x2_pkg::DIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         pix2x2_pkg::REG_IMAGE_WIDTH: begin
            prdata[pix2x2_pkg::DIM_W-1:0] = image_width_ff;
         end
         pix2x2_pkg::REG_IMAGE_HEIGHT: begin
            prdata[pix2x2_pkg::DIM_W-1:0] = image_height_ff;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Effective dimensions: saturate into 2..MAX, even parts bound blocks
   // ---------------------------------------------------------------
   logic [pix2x2_pkg::DIM_W-1:0] eff_width;
   logic [pix2x2_pkg::DIM_W-1:0] eff_height;
   logic [pix2x2_pkg::DIM_W-1:0] even_width;
   logic [pix2x2_pkg::DIM_W-1:0] even_height;

   assign eff_width   = pix2x2_pkg::clamp_dim(image_width_ff, pix2x2_pkg::MAX_WIDTH_V);
   assign eff_height  = pix2x2_pkg::clamp_dim(image_height_ff, pix2x2_pkg::MAX_HEIGHT_V);
   assign even_width  = {eff_width[pix2x2_pkg::DIM_W-1:1], 1'b0};
   assign even_height = {eff_height[pix2x2_pkg::DIM_W-1:1], 1'b0};

   // ---------------------------------------------------------------
   // Handshake and pipeline control
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_take;    // output register can load this cycle
   logic s1_advance;  // stage 1 moves into the output register
   logic accept;

   assign out_take   = ~rsp_valid_ff | rsp_ready;
   assign s1_advance = s1_valid_ff & out_take;
   assign req_ready  = ~s1_valid_ff | out_take;
   assign accept     = req_valid & req_ready;

   // ---------------------------------------------------------------
   // Position counters and held pixel
   // ---------------------------------------------------------------
   logic [pix2x2_pkg::COL_W-1:0]  col_count_ff;
   logic [pix2x2_pkg::ROW_W-1:0]  row_count_ff;
   logic [pix2x2_pkg::PIXEL_W-1:0] held_pixel_ff;
   logic [pix2x2_pkg::COL_W-1:0]  col_count_in;
   logic [pix2x2_pkg::ROW_W-1:0]  row_count_in;
   logic [pix2x2_pkg::DIM_W-1:0]  col_plus;
   logic [pix2x2_pkg::DIM_W-1:0]  row_plus;
   logic                          in_block;
   logic                          odd_col;
   logic                          odd_row;
   logic                          is_last;
   logic [pix2x2_pkg::PAIR_W-1:0] pair_sum;

   assign in_block = (pix2x2_pkg::DIM_W'(row_count_ff) < even_height)
                   & (pix2x2_pkg::DIM_W'(col_count_ff) < even_width);
   assign odd_col  = col_count_ff[0];
   assign odd_row  = row_count_ff[0];
   assign is_last  = (pix2x2_pkg::DIM_W'(row_count_ff) == even_height - pix2x2_pkg::DIM_W'(1))
                   & (pix2x2_pkg::DIM_W'(col_count_ff) == even_width - pix2x2_pkg::DIM_W'(1));
   assign pair_sum = pix2x2_pkg::PAIR_W'(held_pixel_ff) + pix2x2_pkg::PAIR_W'(req_pixel);

   // Advance column; wrap into the next row, and the row into a new image.
   always_comb begin
      col_plus     = pix2x2_pkg::DIM_W'(col_count_ff) + pix2x2_pkg::DIM_W'(1);
      row_plus     = pix2x2_pkg::DIM_W'(row_count_ff) + pix2x2_pkg::DIM_W'(1);
      col_count_in = col_plus[pix2x2_pkg::COL_W-1:0];
      row_count_in = row_count_ff;
      if (col_plus >= eff_width) begin
         col_count_in = '0;
         row_count_in = row_plus[pix2x2_pkg::ROW_W-1:0];
         if (row_plus >= eff_height) begin
            row_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff  <= '0;
         row_count_ff  <= '0;
         held_pixel_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         if (in_block & ~odd_col) begin
            held_pixel_ff <= req_pixel;
         end
      end
   end

   // ---------------------------------------------------------------
   // Pair-sum line memory: written on even rows, read on odd rows.
   // A given entry is written at least one full row before it is read,
   // so no forwarding is needed.
   // ---------------------------------------------------------------
   logic [pix2x2_pkg::PAIR_W-1:0] line_mem [pix2x2_pkg::LINE_DEPTH];
   logic [pix2x2_pkg::PAIR_W-1:0] line_rd_ff;
   logic [pix2x2_pkg::ADDR_W-1:0] line_addr;
   logic                          line_wr;
   logic                          line_rd;

   assign line_addr = col_count_ff[pix2x2_pkg::ADDR_W:1];
   assign line_wr   = accept & in_block & odd_col & ~odd_row;
   assign line_rd   = accept & in_block & odd_col & odd_row;

   always_ff @(posedge clock) begin
      if (line_wr) begin
         line_mem[line_addr] <= pair_sum;
      end
      if (line_rd) begin
         line_rd_ff <= line_mem[line_addr];
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: hold the lower pair and block coordinates while the
   // upper pair comes out of the memory.
   // ---------------------------------------------------------------
   logic [pix2x2_pkg::PAIR_W-1:0] s1_pair_ff;
   logic [pix2x2_pkg::BLK_W-1:0]  s1_row_ff;
   logic [pix2x2_pkg::BLK_W-1:0]  s1_col_ff;
   logic                          s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (line_rd) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (line_rd) begin
         s1_pair_ff <= pair_sum;
         s1_row_ff  <= row_count_ff[pix2x2_pkg::BLK_W:1];
         s1_col_ff  <= col_count_ff[pix2x2_pkg::BLK_W:1];
         s1_last_ff <= is_last;
      end
   end

   // ---------------------------------------------------------------
   // Output register: add the two pairs, drop the two low bits.
   // ---------------------------------------------------------------
   logic [pix2x2_pkg::SUM_W-1:0]   block_sum;
   logic [pix2x2_pkg::PIXEL_W-1:0] rsp_mean_ff;
   logic [pix2x2_pkg::BLK_W-1:0]   rsp_row_ff;
   logic [pix2x2_pkg::BLK_W-1:0]   rsp_col_ff;
   logic                           rsp_last_ff;

   assign block_sum = pix2x2_pkg::SUM_W'(line_rd_ff) + pix2x2_pkg::SUM_W'(s1_pair_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_mean_ff <= block_sum[pix2x2_pkg::SUM_W-1:2];
         rsp_row_ff  <= s1_row_ff;
         rsp_col_ff  <= s1_col_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_mean = rsp_mean_ff;
   assign rsp_block_row  = rsp_row_ff;
   assign rsp_block_col  = rsp_col_ff;
   assign rsp_last_block = rsp_last_ff;

endmodule
`default_nettype wire
